>>> rtl/isl_pkg.sv
// isl_pkg: shared types, codes and defaults for the indexed shift list.
// Used by isl_cell, isl_ctrl and indexed_shift_list; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package isl_pkg;

  // Defaults for the top-level parameters
  localparam int CapacityDef  = 16;
  localparam int DataWidthDef = 32;

  // Cell index width, wide enough for a capacity of up to 256 cells
  localparam int LIST_IDX_W = 8;

  // Operation codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic [1:0]  operation;
    logic [4:0]  position;
    logic [31:0] value_in;
  } cmd_t;

  typedef struct packed {
    logic [31:0] value_out;
    logic [4:0]  entry_count;
    logic [1:0]  status;
  } res_t;

  // Broadcast from the controller to every cell of the chain
  typedef struct packed {
    logic                  shift_up;
    logic                  shift_down;
    logic                  clear;
    logic [LIST_IDX_W-1:0] from_idx;
  } cell_ctrl_t;

  // Outcome of one operation, for the result register
  typedef struct packed {
    logic [1:0] status;
    logic       take_value;
  } op_status_t;

endpackage

`default_nettype wire

>>> rtl/indexed_shift_list.sv
// indexed_shift_list: top level; an ordered list kept in a chain of cells.
// Depends on isl_pkg, isl_ctrl and isl_cell.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-----------------------------------
//   command  | start_i / busy_o       | cmd_i (operation, position, value_in)
//   result   | res_valid_o (strobe)   | res_o (value_out, entry_count, status)
//
// A command transaction is taken at every edge where start_i is high; busy_o
// never rises, so one transaction enters per clock cycle.
// Its result is registered; res_valid_o strobes it for exactly one cycle, the cycle after acceptance.
// Insert and remove move every later cell by one slot in that same cycle:
// each cell loads from its left or right neighbor, so the chain sets no limit.
// Reset clears every cell and the count at once; no sweep is needed.
// The receiver cannot stall; a result not taken in its cycle is gone.
`timescale 1ns / 1ps
`default_nettype none

module indexed_shift_list #(
  parameter int CAPACITY   = isl_pkg::CapacityDef,
  parameter int DATA_WIDTH = isl_pkg::DataWidthDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  output logic               busy_o,
  input  wire isl_pkg::cmd_t cmd_i,
  output logic               res_valid_o,
  output isl_pkg::res_t      res_o
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);

  isl_pkg::cell_ctrl_t   cell_ctrl;
  isl_pkg::op_status_t   op_status;
  logic [DATA_WIDTH-1:0] ins_data;
  logic [CNT_W-1:0]      count_d, count_q;
  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];

  logic                  accept;
  logic [8:0]            pos9, cnt_d9, cnt_q9;
  logic [DATA_WIDTH-1:0] rd_data;
  logic [63:0]           rd_ext;

  isl_pkg::res_t res_q, res_d;
  logic          res_valid_q;

  // No backpressure: every start is accepted
  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  isl_ctrl #(
    .CAPACITY  (CAPACITY),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .cmd_i      (cmd_i),
    .cell_ctrl_o(cell_ctrl),
    .ins_data_o (ins_data),
    .op_status_o(op_status),
    .count_d_o  (count_d),
    .count_q_o  (count_q)
  );

  // The chain: cell 0 has nothing on its left, the last cell pulls in zero
  // from its right so the freed slot is cleared on remove.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_data[i+1];
    end
    isl_cell #(
      .DATA_WIDTH(DATA_WIDTH),
      .INDEX     (i)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (cell_ctrl),
      .ins_data_i(ins_data),
      .left_i    (left),
      .right_i   (right),
      .data_o    (cell_data[i])
    );
  end

  // Pick the addressed entry before the chain moves; out-of-range picks are
  // masked by take_value.
  assign pos9    = {4'b0, cmd_i.position};
  assign cnt_d9  = 9'(count_d);
  assign cnt_q9  = 9'(count_q);
  assign rd_data = cell_data[pos9[IDX_W-1:0]];
  assign rd_ext  = 64'(rd_data);

  always_comb begin
    res_d.value_out   = op_status.take_value ? rd_ext[31:0] : 32'd0;
    res_d.entry_count = cnt_d9[4:0];
    res_d.status      = op_status.status;
  end

  // Register the result of each accepted transaction; payload needs no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= accept;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // Each accepted transaction yields exactly one strobe, in the next cycle
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> res_valid_o)
    else $error("accepted transaction produced no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> !res_valid_o)
    else $error("result strobe without a transaction");

  // Count stays within capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q9 <= 9'(CAPACITY))
    else $error("entry count beyond capacity");

  // The first slot past the end of the list is always empty
  a_tail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q9 < 9'(CAPACITY)) |-> (cell_data[cnt_q9[IDX_W-1:0]] == '0))
    else $error("slot past the end of the list holds data");

  // Clear reports an empty list and no data
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_i.operation == isl_pkg::OP_CLEAR)
      |=> (res_o.entry_count == 5'd0 && res_o.value_out == 32'd0))
    else $error("clear left entries behind");

endmodule

`default_nettype wire

>>> rtl/isl_cell.sv
// isl_cell: one slot of the list; holds a word and trades it with its neighbors.
// Depends on isl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module isl_cell #(
  parameter int DATA_WIDTH = isl_pkg::DataWidthDef,
  parameter int INDEX      = 0
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire isl_pkg::cell_ctrl_t   ctrl_i,
  input  wire logic [DATA_WIDTH-1:0] ins_data_i,
  input  wire logic [DATA_WIDTH-1:0] left_i,
  input  wire logic [DATA_WIDTH-1:0] right_i,
  output logic      [DATA_WIDTH-1:0] data_o
);

  localparam logic [isl_pkg::LIST_IDX_W-1:0] CellIdx = isl_pkg::LIST_IDX_W'(INDEX);

  logic [DATA_WIDTH-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    priority if (ctrl_i.clear) begin
      data_d = '0;
    end else if (ctrl_i.shift_up && CellIdx == ctrl_i.from_idx) begin
      data_d = ins_data_i;
    end else if (ctrl_i.shift_up && CellIdx > ctrl_i.from_idx) begin
      data_d = left_i;
    end else if (ctrl_i.shift_down && CellIdx >= ctrl_i.from_idx) begin
      data_d = right_i;
    end else begin
      data_d = data_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

>>> rtl/isl_ctrl.sv
// isl_ctrl: decodes a command, checks it against the entry count and drives
// the cell chain. Holds the count register. Depends on isl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module isl_ctrl #(
  parameter int CAPACITY   = isl_pkg::CapacityDef,
  parameter int DATA_WIDTH = isl_pkg::DataWidthDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire isl_pkg::cmd_t                 cmd_i,
  output isl_pkg::cell_ctrl_t                cell_ctrl_o,
  output logic      [DATA_WIDTH-1:0]         ins_data_o,
  output isl_pkg::op_status_t                op_status_o,
  output logic      [$clog2(CAPACITY+1)-1:0] count_d_o,
  output logic      [$clog2(CAPACITY+1)-1:0] count_q_o
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0] count_q, count_d;
  logic [8:0]       pos9, cnt9;
  logic [63:0]      val_ext;
  logic [DATA_WIDTH-1:0] val;

  assign pos9    = {4'b0, cmd_i.position};
  assign cnt9    = 9'(count_q);
  assign val_ext = 64'(cmd_i.value_in);
  assign val     = val_ext[DATA_WIDTH-1:0];

  always_comb begin
    count_d     = count_q;
    cell_ctrl_o = '0;
    op_status_o = '{status: isl_pkg::ST_OK, take_value: 1'b0};
    if (start_i) begin
      unique case (cmd_i.operation)
        isl_pkg::OP_INSERT: begin
          priority if (val == '0) begin
            op_status_o.status = isl_pkg::ST_EMPTY;
          end else if (cnt9 >= 9'(CAPACITY)) begin
            op_status_o.status = isl_pkg::ST_FULL;
          end else begin
            // An index past the end appends
            cell_ctrl_o.shift_up = 1'b1;
            cell_ctrl_o.from_idx = (pos9 > cnt9) ? cnt9[isl_pkg::LIST_IDX_W-1:0]
                                                 : pos9[isl_pkg::LIST_IDX_W-1:0];
            count_d = count_q + CNT_W'(1);
          end
        end
        isl_pkg::OP_REMOVE: begin
          if (pos9 >= cnt9) begin
            op_status_o.status = isl_pkg::ST_RANGE;
          end else begin
            cell_ctrl_o.shift_down = 1'b1;
            cell_ctrl_o.from_idx   = pos9[isl_pkg::LIST_IDX_W-1:0];
            op_status_o.take_value = 1'b1;
            count_d = count_q - CNT_W'(1);
          end
        end
        isl_pkg::OP_READ: begin
          if (pos9 >= cnt9) begin
            op_status_o.status = isl_pkg::ST_RANGE;
          end else begin
            op_status_o.take_value = 1'b1;
          end
        end
        isl_pkg::OP_CLEAR: begin
          cell_ctrl_o.clear = 1'b1;
          count_d = '0;
        end
        default: begin
          count_d = count_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign ins_data_o = val;
  assign count_d_o  = count_d;
  assign count_q_o  = count_q;

endmodule

`default_nettype wire

>>> verif/tb.sv
// tb: self-checking regression for indexed_shift_list with a small list tracker
// that predicts every result. Depends on isl_pkg and the indexed_shift_list RTL.
`timescale 1ns / 1ps

module tb;
  import isl_pkg::*;

  localparam int CAP = CapacityDef;

  // Track the list contents and hold the results still owed by the block.
  class list_tracker;
    logic [31:0] slots [CAP];
    int          filled;
    res_t        owed [$];
    int          fails;

    function new();
      foreach (slots[i]) slots[i] = '0;
      filled = 0;
      fails  = 0;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      fails++;
    endtask

    // Apply one accepted transaction and queue the result it must produce.
    function void note_cmd(cmd_t c);
      res_t e;
      int   p;
      e = '0;
      e.status = ST_OK;
      case (c.operation)
        OP_INSERT: begin
          if (c.value_in == '0) begin
            e.status = ST_EMPTY;
          end else if (filled >= CAP) begin
            e.status = ST_FULL;
          end else begin
            p = (int'(c.position) > filled) ? filled : int'(c.position);
            for (int i = filled; i > p; i--) slots[i] = slots[i-1];
            slots[p] = c.value_in;
            filled++;
          end
        end
        OP_REMOVE: begin
          if (int'(c.position) >= filled) begin
            e.status = ST_RANGE;
          end else begin
            p = int'(c.position);
            e.value_out = slots[p];
            for (int i = p; i + 1 < filled; i++) slots[i] = slots[i+1];
            slots[filled-1] = '0;
            filled--;
          end
        end
        OP_READ: begin
          if (int'(c.position) >= filled) e.status = ST_RANGE;
          else e.value_out = slots[c.position];
        end
        default: begin
          foreach (slots[i]) slots[i] = '0;
          filled = 0;
        end
      endcase
      e.entry_count = 5'(filled);
      owed.push_back(e);
    endfunction

    task check_result(res_t r);
      res_t e;
      if (owed.size() == 0) begin
        report_mismatch($sformatf("result with nothing owed: %0h", r));
        return;
      end
      e = owed.pop_front();
      if (r.value_out !== e.value_out)
        report_mismatch($sformatf("value_out %0h, want %0h", r.value_out, e.value_out));
      if (r.entry_count !== e.entry_count)
        report_mismatch($sformatf("entry_count %0d, want %0d", r.entry_count, e.entry_count));
      if (r.status !== e.status)
        report_mismatch($sformatf("status %0d, want %0d", r.status, e.status));
    endtask
  endclass

  logic clk_i   = 1'b0;
  logic rst_ni  = 1'b0;
  logic start_i = 1'b0;
  cmd_t cmd_i   = '0;
  logic busy_o;
  logic res_valid_o;
  res_t res_o;

  list_tracker book;
  bit          quiet;   // no idle cycles in this phase

  indexed_shift_list uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .cmd_i      (cmd_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs or never strobes a result.
  initial begin
    #2_000_000;
    $display("indexed_shift_list regression: fail");
    $finish;
  end

  // Check each strobed result in the cycle it is presented; the receiver
  // cannot stall, so sample it at the edge that closes that cycle.
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) book.check_result(res_o);
  end

  function int draw_gap();
    return quiet ? 0 : $urandom_range(0, 12);
  endfunction

  // Idle for the drawn gap, present the transaction, and hold it until the
  // block takes it. Return at the acceptance edge so a zero gap keeps start
  // high without a second assignment in that time step.
  task automatic drive_cmd(input cmd_t c, input int gap);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    cmd_i   <= c;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    book.note_cmd(c);
  endtask

  task automatic issue(input logic [1:0] op, input logic [4:0] pos, input logic [31:0] val);
    cmd_t c;
    c.operation = op;
    c.position  = pos;
    c.value_in  = val;
    drive_cmd(c, draw_gap());
  endtask

  // Drop start and hold off until every owed result has come back.
  task automatic drain();
    start_i <= 1'b0;
    do @(posedge clk_i); while (book.pending() != 0);
  endtask

  // Draw one random transaction; the mix leans toward filling, draining or
  // neither so the list swings between empty and full.
  function automatic cmd_t draw_cmd(input int lean);
    cmd_t c;
    int   r;
    int   ins_w;
    int   rem_w;
    int   rd_w;
    r = $urandom_range(0, 99);
    case (lean)
      0:       begin ins_w = 70; rem_w = 10; rd_w = 17; end
      1:       begin ins_w = 25; rem_w = 55; rd_w = 17; end
      default: begin ins_w = 45; rem_w = 35; rd_w = 18; end
    endcase
    if (r < ins_w)                     c.operation = OP_INSERT;
    else if (r < ins_w + rem_w)        c.operation = OP_REMOVE;
    else if (r < ins_w + rem_w + rd_w) c.operation = OP_READ;
    else                               c.operation = OP_CLEAR;
    // Mostly in range (count itself hits the boundary); sometimes anywhere.
    if ($urandom_range(0, 4) != 0) c.position = 5'($urandom_range(0, book.filled));
    else                           c.position = 5'($urandom_range(0, 31));
    r = $urandom_range(0, 19);
    if (r == 0)      c.value_in = '0;
    else if (r == 1) c.value_in = '1;
    else             c.value_in = $urandom;
    return c;
  endfunction

  initial begin
    int lean;
    book = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty-list range errors, empty value, append past count,
    // front and middle inserts, full list, empty-value priority over full.
    quiet = 1'b0;
    issue(OP_READ,   5'd0,  32'h1234_5678);
    issue(OP_REMOVE, 5'd0,  32'h0);
    issue(OP_INSERT, 5'd3,  32'h0);
    issue(OP_INSERT, 5'd31, 32'hFFFF_FFFF);
    issue(OP_INSERT, 5'd0,  32'h0000_0001);
    issue(OP_INSERT, 5'd1,  32'h8000_0000);
    issue(OP_READ,   5'd2,  32'h0);
    issue(OP_READ,   5'd3,  32'h0);
    issue(OP_REMOVE, 5'd1,  32'h0);
    issue(OP_READ,   5'd31, 32'h0);
    issue(OP_CLEAR,  5'd16, 32'hFFFF_FFFF);
    quiet = 1'b1;
    for (int i = 0; i < CAP; i++) issue(OP_INSERT, 5'(i), 32'hA5A5_0000 | i);
    issue(OP_INSERT, 5'd16, 32'h5A5A_5A5A);
    issue(OP_INSERT, 5'd0,  32'h0);
    issue(OP_READ,   5'd15, 32'h0);
    issue(OP_REMOVE, 5'd15, 32'h0);
    issue(OP_REMOVE, 5'd0,  32'h0);
    issue(OP_READ,   5'd16, 32'h0);
    issue(OP_CLEAR,  5'd0,  32'h0);
    drain();

    // Random phases of 50 transactions, each with its own lean and idling.
    for (int ph = 0; ph < 23; ph++) begin
      lean  = $urandom_range(0, 2);
      quiet = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < 50; n++) drive_cmd(draw_cmd(lean), draw_gap());
      if ($urandom_range(0, 3) == 0) drain();
    end

    drain();
    repeat (4) @(posedge clk_i);
    if (book.fails == 0 && book.pending() == 0) begin
      $display("indexed_shift_list regression: pass");
    end else begin
      $display("indexed_shift_list regression: fail");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/isl_pkg.sv
rtl/isl_cell.sv
rtl/isl_ctrl.sv
rtl/indexed_shift_list.sv
verif/tb.sv
